>>> src/ests_pkg.sv
// Shared constants for the exponential search block: field widths,
// stream packing widths and operation codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ests_pkg;

   // Field widths
   localparam int OP_W    = 1;
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;
   localparam int LEN_W   = 11;
   localparam int POS_W   = 10;

   // Stream packing: data fields packed low first, padded to whole bytes
   localparam int REQ_DATA_W = ((INDEX_W + VALUE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((POS_W + 7) / 8) * 8;

   // Request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_WRITE  = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

endpackage

`default_nettype wire

>>> src/ests_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing; width and depth are parameters.
`timescale 1ns / 1ps
`default_nettype none

module ests_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write on enable, always register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

`default_nettype wire

>>> src/exponential_search_sorted_table_top.sv
// Exponential search over a sorted table held in one synchronous RAM.
// Depends on ests_pkg and ests_ram.
//
// Usage:
//   req channel: tuser = op (write or search), tdata = entry_index and
//   data_value. A write stores data_value at entry_index with no response. A
//   search seeks data_value in entries 0 .. min(used_length, TABLE_DEPTH)-1.
//   rsp channel: tuser = found, tdata = position (zero when not found).
//   csr port: csr_wr_en writes used_length; change it only while idle.
// Sequence:
//   A write leaves the block idle, so it stays ready for the next request.
//   A search reads entry 0 (S_ZERO), then any doubling probes (S_PROBE),
//   sets the halving bounds (S_SETUP) and makes halving steps (S_BIN), each
//   probe and step one RAM read; a hit or zero length ends it early. S_DONE
//   loads the response register. One request is in flight at a time;
//   req_tready is high only when the search engine is idle.
// Reset:
//   Clears control state and sets used_length to 1. The table is not
//   cleared; entries must be written before they are searched.
// Stalls:
//   The response sits in an output register. Writes are still taken while
//   it waits; a search that finishes holds in its final state until the
//   output register is free.
`timescale 1ns / 1ps
`default_nettype none

module exponential_search_sorted_table_top #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [9:0] entry_index, [41:10] data_value
   input  wire logic [ests_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic [ests_pkg::OP_W-1:0]      req_tuser,  // [0] op
   // response channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [ests_pkg::RSP_DATA_W-1:0] rsp_tdata, // [9:0] position
   output logic                                rsp_tuser,  // [0] found
   // configuration
   input  wire logic                           csr_wr_en,
   input  wire logic [ests_pkg::LEN_W-1:0]     csr_wr_data
);
   import ests_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int LW = IW + 1;
   localparam int CW = (LW > LEN_W) ? LW : LEN_W;
   localparam int EW = (LW > INDEX_W) ? LW : INDEX_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ZERO,
      S_PROBE,
      S_SETUP,
      S_BIN,
      S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [LEN_W-1:0]        used_length_ff, used_length_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [LW-1:0]           probe_ff, probe_in;
   logic [LW-1:0]           lo_ff, lo_in;
   logic [LW-1:0]           hx_ff, hx_in;
   logic [IW-1:0]           mid_ff, mid_in;
   logic                    res_found_ff, res_found_in;
   logic [POS_W-1:0]        res_pos_ff, res_pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;

   logic                    ram_we;
   logic [IW-1:0]           ram_addr;
   logic [VALUE_W-1:0]      ram_rdata;
   logic signed [VALUE_W-1:0] entry;

   logic                    req_fire;
   logic [INDEX_W-1:0]      req_index;
   logic signed [VALUE_W-1:0] req_value;
   logic                    wr_in_range;
   logic [LW-1:0]           eff_len;
   logic [LW-1:0]           last_ext;

   // Binary step: mid = floor((lo + hx - 1) / 2), hx exclusive
   function automatic logic [IW-1:0] mid_of(input logic [LW-1:0] lo,
                                            input logic [LW-1:0] hx);
      logic [LW:0] sum;
      sum = {1'b0, lo} + {1'b0, hx} - (LW+1)'(1);
      return IW'(sum >> 1);
   endfunction

   assign req_fire  = req_tvalid && req_tready;
   assign req_index = req_tdata[INDEX_W-1:0];
   assign req_value = $signed(req_tdata[INDEX_W +: VALUE_W]);
   assign entry     = $signed(ram_rdata);

   // Clamp the used length to the table depth
   always_comb begin
      if (CW'(used_length_ff) > CW'(TABLE_DEPTH)) begin
         eff_len = LW'(TABLE_DEPTH);
      end else begin
         eff_len = LW'(used_length_ff);
      end
   end

   assign last_ext    = eff_len - LW'(1);
   assign wr_in_range = EW'(req_index) < EW'(TABLE_DEPTH);

   ests_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (req_value),
      .rd_data (ram_rdata)
   );

   // Next state, RAM access and result capture
   always_comb begin
      logic [LW-1:0] nprobe;
      logic [LW-1:0] nlo;
      logic [LW-1:0] nhx;
      logic [IW-1:0] nmid;

      state_in       = state_ff;
      used_length_in = used_length_ff;
      key_in         = key_ff;
      probe_in       = probe_ff;
      lo_in          = lo_ff;
      hx_in          = hx_ff;
      mid_in         = mid_ff;
      res_found_in   = res_found_ff;
      res_pos_in     = res_pos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_found_in   = rsp_found_ff;
      rsp_pos_in     = rsp_pos_ff;
      ram_we         = 1'b0;
      ram_addr       = '0;
      nprobe         = '0;
      nlo            = '0;
      nhx            = '0;
      nmid           = '0;

      if (csr_wr_en) begin
         used_length_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (op_type'(req_tuser) == OP_WRITE) begin
                  ram_we   = wr_in_range;
                  ram_addr = IW'(req_index);
               end else begin
                  key_in = req_value;
                  if (eff_len == '0) begin
                     res_found_in = 1'b0;
                     res_pos_in   = '0;
                     state_in     = S_DONE;
                  end else begin
                     ram_addr = '0;
                     state_in = S_ZERO;
                  end
               end
            end
         end

         // Entry 0 is back; start probing at index 1
         S_ZERO: begin
            if (entry == key_ff) begin
               res_found_in = 1'b1;
               res_pos_in   = '0;
               state_in     = S_DONE;
            end else begin
               probe_in = LW'(1);
               if (last_ext != '0) begin
                  ram_addr = IW'(1);
                  state_in = S_PROBE;
               end else begin
                  state_in = S_SETUP;
               end
            end
         end

         // Double the probe while the entry is at most the key
         S_PROBE: begin
            if (entry <= key_ff) begin
               nprobe   = probe_ff << 1;
               probe_in = nprobe;
               if (nprobe <= last_ext) begin
                  ram_addr = IW'(nprobe);
               end else begin
                  state_in = S_SETUP;
               end
            end else begin
               state_in = S_SETUP;
            end
         end

         // Set the halving bounds and issue the first midpoint read
         S_SETUP: begin
            nlo = probe_ff >> 1;
            nhx = ((probe_ff < last_ext) ? probe_ff : last_ext) + LW'(1);
            nmid  = mid_of(nlo, nhx);
            lo_in = nlo;
            hx_in = nhx;
            if (nlo < nhx) begin
               ram_addr = nmid;
               mid_in   = nmid;
               state_in = S_BIN;
            end else begin
               res_found_in = 1'b0;
               res_pos_in   = '0;
               state_in     = S_DONE;
            end
         end

         // Compare the midpoint, narrow the range, read the next midpoint
         S_BIN: begin
            if (entry == key_ff) begin
               res_found_in = 1'b1;
               res_pos_in   = POS_W'(mid_ff);
               state_in     = S_DONE;
            end else begin
               if (entry > key_ff) begin
                  nlo = lo_ff;
                  nhx = LW'(mid_ff);
               end else begin
                  nlo = LW'(mid_ff) + LW'(1);
                  nhx = hx_ff;
               end
               nmid  = mid_of(nlo, nhx);
               lo_in = nlo;
               hx_in = nhx;
               if (nlo < nhx) begin
                  ram_addr = nmid;
                  mid_in   = nmid;
               end else begin
                  res_found_in = 1'b0;
                  res_pos_in   = '0;
                  state_in     = S_DONE;
               end
            end
         end

         // Hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_pos_in   = res_pos_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         used_length_ff <= LEN_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         used_length_ff <= used_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      key_ff       <= key_in;
      probe_ff     <= probe_in;
      lo_ff        <= lo_in;
      hx_ff        <= hx_in;
      mid_ff       <= mid_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_pos_ff);

endmodule

`default_nettype wire

>>> src/ests_checker.sv
// Port-level checks for the exponential search block, bound to its top level.
// Depends on ests_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ests_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [ests_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tuser
);
   import ests_pkg::*;

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // A miss reports position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with nonzero position");

   // No response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // A request never produces a response in the very next cycle
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response appeared one cycle after a request");

endmodule

bind exponential_search_sorted_table_top ests_checker u_ests_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for exponential_search_sorted_table_top: fills the table,
// sets the used length and checks each search response against a local predictor.
// Depends on ests_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
   import ests_pkg::*;

   localparam int      TABLE_DEPTH   = 1024;
   localparam int      SETTLE_CYCLES = 30;
   localparam int      DRAIN_CYCLES  = 40;
   localparam int      CYCLE_LIMIT   = 400000;
   localparam longint  VALUE_MIN     = -64'sd2147483648;
   localparam longint  VALUE_MAX     = 64'sd2147483647;

   typedef enum int {SHAPE_WIDE, SHAPE_DENSE, SHAPE_SCRAMBLED} fill_shape_type;

   typedef struct packed {
      logic               found;
      logic [POS_W-1:0]   position;
   } search_answer_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [OP_W-1:0]        req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_wr_en;
   logic [LEN_W-1:0]       csr_wr_data;

   // Predictor state: table contents and used length as the block should hold them
   logic signed [VALUE_W-1:0] entry_values [TABLE_DEPTH];
   int                        used_length_now;
   search_answer_type         expected_answers [$];

   bit idle_en;
   bit quiet;
   int rsp_hold;
   int cycle_count;
   int mismatches;
   int searches_sent;
   int writes_sent;
   int responses_seen;
   int hits_seen;
   int length_writes;

   exponential_search_sorted_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses pending", cycle_count,
                  expected_answers.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Exponential probe from index 1, then binary search over the last doubling window
   function automatic search_answer_type expected_search_answer(
      input logic signed [VALUE_W-1:0] target);
      search_answer_type answer;
      int span, last, probe, lo, hi, mid;
      answer = '0;
      span = (used_length_now > TABLE_DEPTH) ? TABLE_DEPTH : used_length_now;
      if (span == 0) return answer;
      if (entry_values[0] == target) begin
         answer.found = 1'b1;
         return answer;
      end
      last = span - 1;
      probe = 1;
      while (probe <= last && entry_values[probe] <= target) probe = probe * 2;
      lo = probe / 2;
      hi = (probe < last) ? probe : last;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (entry_values[mid] == target) begin
            answer.found = 1'b1;
            answer.position = mid[POS_W-1:0];
            return answer;
         end
         if (entry_values[mid] > target) hi = mid - 1;
         else lo = mid + 1;
      end
      return answer;
   endfunction

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endfunction

   // Target near the live entries most of the time, extremes and noise otherwise
   function automatic logic signed [VALUE_W-1:0] pick_target(input int span);
      int roll;
      logic signed [VALUE_W-1:0] near;
      roll = $urandom_range(0, 99);
      near = entry_values[$urandom_range(0, ((span > TABLE_DEPTH) ? TABLE_DEPTH : span) - 1)];
      if (roll < 55) return near;
      if (roll < 75) return roll[0] ? near + 1 : near - 1;
      if (roll < 85) return $urandom;
      if (roll < 90) return 32'sh8000_0000;
      if (roll < 95) return 32'sh7fff_ffff;
      return $urandom;
   endfunction

   // Send one request; valid stays high until the next request or a pause lowers it
   task automatic send_request(input op_type op, input logic [INDEX_W-1:0] index,
                               input logic signed [VALUE_W-1:0] value);
      int gap;
      gap = (idle_en && !quiet && $urandom_range(0, 99) < 20) ? $urandom_range(1, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W - INDEX_W - VALUE_W){1'b0}}, value, index};
      do @(posedge clock); while (!req_tready);
      if (op == OP_WRITE) begin
         entry_values[index] = value;
         writes_sent++;
      end else begin
         expected_answers.push_back(expected_search_answer(value));
         searches_sent++;
      end
   endtask

   // Change the length only once the block has gone quiet
   task automatic set_used_length(input int length);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= length[LEN_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      used_length_now = length;
      length_writes++;
   endtask

   // Write entries 0..count-1 in ascending, duplicate-heavy or scrambled order
   task automatic fill_table(input int count, input fill_shape_type shape);
      longint next_value, step_floor, step_cap;
      logic signed [VALUE_W-1:0] value;
      if (shape == SHAPE_DENSE) begin
         next_value = longint'(int'($urandom));
         if (next_value > VALUE_MAX - 4 * count) next_value = VALUE_MAX - 4 * count;
         step_floor = 0;
         step_cap = 3;
      end else begin
         next_value = VALUE_MIN;
         if ($urandom_range(0, 3) != 0) next_value += longint'($urandom_range(0, 32'h7fff_ffff));
         step_floor = 1;
         step_cap = (VALUE_MAX - next_value) / count;
      end
      for (int k = 0; k < count; k++) begin
         value = (shape == SHAPE_SCRAMBLED) ? $urandom : next_value[VALUE_W-1:0];
         send_request(OP_WRITE, k[INDEX_W-1:0], value);
         next_value += longint'($urandom_range(32'(step_cap), 32'(step_floor)));
      end
   endtask

   // Mostly searches, with stray writes anywhere in the table
   task automatic run_mixed(input int span, input int count);
      repeat (count) begin
         if ($urandom_range(0, 99) < 15)
            send_request(OP_WRITE, 10'($urandom_range(0, TABLE_DEPTH - 1)), $urandom);
         else
            send_request(OP_SEARCH, 10'($urandom_range(0, TABLE_DEPTH - 1)), pick_target(span));
      end
   endtask

   // Compare each response with the oldest prediction
   always @(posedge clock) begin : check_responses
      search_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (rsp_tuser) hits_seen++;
         if (expected_answers.size() == 0) begin
            note_mismatch($sformatf("unexpected response found=%0b position=%0d",
                                    rsp_tuser, rsp_tdata[POS_W-1:0]));
         end else begin
            want = expected_answers.pop_front();
            if (rsp_tuser !== want.found || rsp_tdata[POS_W-1:0] !== want.position)
               note_mismatch($sformatf(
                  "expected found=%0b position=%0d, got found=%0b position=%0d",
                  want.found, want.position, rsp_tuser, rsp_tdata[POS_W-1:0]));
         end
      end
   end

   // Stall the response side in random bursts
   always @(negedge clock) begin
      if (reset || quiet || !idle_en) begin
         rsp_tready <= 1'b1;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 15) begin
         rsp_hold = $urandom_range(1, 12) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // One entry at reset length, hit and miss
   task automatic test_single_entry();
      send_request(OP_WRITE, 10'd0, -32'sd5);
      send_request(OP_SEARCH, 10'd0, -32'sd5);
      send_request(OP_SEARCH, 10'h3ff, 32'sd7);
   endtask

   // Zero length answers not found without touching the table
   task automatic test_empty_table();
      set_used_length(0);
      send_request(OP_SEARCH, 10'd0, -32'sd5);
   endtask

   // Full value range, a duplicate pair and the top index
   task automatic test_edge_values();
      send_request(OP_WRITE, 10'd0, 32'sh8000_0000);
      send_request(OP_WRITE, 10'd1, -32'sd1000);
      send_request(OP_WRITE, 10'd2, -32'sd1);
      send_request(OP_WRITE, 10'd3, 32'sd0);
      send_request(OP_WRITE, 10'd4, 32'sd0);
      send_request(OP_WRITE, 10'd5, 32'sd5);
      send_request(OP_WRITE, 10'd6, 32'sd1000);
      send_request(OP_WRITE, 10'd7, 32'sh7fff_ffff);
      send_request(OP_WRITE, 10'h3ff, 32'sh5555_aaaa);
      set_used_length(8);
      send_request(OP_SEARCH, 10'd0, 32'sh8000_0000);
      send_request(OP_SEARCH, 10'h3ff, 32'sh7fff_ffff);
      send_request(OP_SEARCH, 10'd3, 32'sd0);
      send_request(OP_SEARCH, 10'd5, 32'sd5);
      send_request(OP_SEARCH, 10'd6, 32'sd6);
   endtask

   // Short tables of randomly chosen shapes, each searched over part or all of its fill
   task automatic test_random_tables();
      int filled, span, roll;
      fill_shape_type shape;
      for (int phase = 0; phase < 3; phase++) begin
         filled = (phase == 0) ? 1 : $urandom_range(2, 12);
         roll = $urandom_range(0, 5);
         shape = (roll == 0) ? SHAPE_SCRAMBLED : (roll < 3) ? SHAPE_DENSE : SHAPE_WIDE;
         idle_en = ($urandom_range(0, 3) != 0);
         fill_table(filled, shape);
         span = $urandom_range(1, filled);
         set_used_length(span);
         run_mixed(span, $urandom_range(8, 14));
      end
      idle_en = 1'b1;
   endtask

   // Whole table in use
   task automatic test_full_table();
      fill_table(TABLE_DEPTH, SHAPE_WIDE);
      set_used_length(TABLE_DEPTH);
      run_mixed(TABLE_DEPTH, 24);
   endtask

   // Length beyond the table depth is clipped to it
   task automatic test_oversized_length();
      set_used_length(2047);
      run_mixed(TABLE_DEPTH, 16);
   endtask

   // Back-to-back requests with no pauses and the response side always ready
   task automatic test_final_burst();
      int span;
      quiet = 1'b1;
      span = $urandom_range(512, TABLE_DEPTH);
      set_used_length(span);
      run_mixed(span, 16);
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_WRITE;
      rsp_tready  = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      idle_en     = 1'b1;
      quiet       = 1'b0;
      used_length_now = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_entry();
      test_empty_table();
      test_edge_values();
      test_random_tables();
      test_full_table();
      test_oversized_length();
      test_final_burst();

      // Drain outstanding responses
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d searches (%0d hits) and %0d table writes",
               searches_sent, hits_seen, writes_sent);
      $display("over %0d length settings, from an empty table up to an oversized length;",
               length_writes);
      $display("%0d mismatches in %0d responses.", mismatches, responses_seen);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/ests_pkg.sv
src/ests_ram.sv
src/exponential_search_sorted_table_top.sv
src/ests_checker.sv
dv/tb.sv
